// ----- rtl/core/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// prs_pkg
// shared codes, widths and defaults of the persona reload sequencer
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int OPCODE_W       = 4;
    localparam int PERSONA_W      = 8;
    localparam int STATE_W        = 3;
    localparam int ERROR_W        = 3;
    localparam int COUNT_W        = 32;
    localparam int PERSONA_BITS_D = 8;

    typedef logic [OPCODE_W-1:0]  opcode_t;
    typedef logic [PERSONA_W-1:0] persona_t;
    typedef logic [STATE_W-1:0]   state_t;
    typedef logic [ERROR_W-1:0]   error_t;
    typedef logic [COUNT_W-1:0]   count_t;

    localparam opcode_t OP_RESET       = 4'd0;
    localparam opcode_t OP_REQUEST     = 4'd1;
    localparam opcode_t OP_INVALID     = 4'd2;
    localparam opcode_t OP_BUSY        = 4'd3;
    localparam opcode_t OP_RETAIN      = 4'd4;
    localparam opcode_t OP_VALID       = 4'd5;
    localparam opcode_t OP_QUIESCED    = 4'd6;
    localparam opcode_t OP_UNLOADED    = 4'd7;
    localparam opcode_t OP_LOADED      = 4'd8;
    localparam opcode_t OP_LOAD_FAILED = 4'd9;
    localparam opcode_t OP_RB_LOADED   = 4'd10;
    localparam opcode_t OP_RB_FAILED   = 4'd11;

    localparam state_t ST_STOPPED    = 3'd0;
    localparam state_t ST_ACTIVE     = 3'd1;
    localparam state_t ST_VALIDATING = 3'd2;
    localparam state_t ST_QUIESCING  = 3'd3;
    localparam state_t ST_UNLOADING  = 3'd4;
    localparam state_t ST_LOADING    = 3'd5;
    localparam state_t ST_ROLLBACK   = 3'd6;
    localparam state_t ST_FAULT      = 3'd7;

    localparam error_t ER_NONE       = 3'd0;
    localparam error_t ER_INVALID    = 3'd1;
    localparam error_t ER_BUSY       = 3'd2;
    localparam error_t ER_LOAD       = 3'd3;
    localparam error_t ER_ROLLBACK   = 3'd4;
    localparam error_t ER_TRANSITION = 3'd5;

endpackage

// ----- rtl/core/prs_if.sv -----
// ----------------------------------------------------------------------------
// prs_event_if / prs_status_if
// valid/ready channels for event items and status results
// ----------------------------------------------------------------------------
interface prs_event_if
    import prs_pkg::*;
();
    logic     valid;
    logic     ready;
    opcode_t  opcode;
    persona_t wanted_persona;

    modport source (output valid, output opcode, output wanted_persona, input ready);
    modport sink   (input valid, input opcode, input wanted_persona, output ready);
endinterface

interface prs_status_if
    import prs_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     accepted;
    state_t   new_state;
    error_t   error_code;
    persona_t active_persona;
    persona_t goal_persona;
    persona_t fallback_persona;
    count_t   transition_count;

    modport source (
        output valid, output accepted, output new_state, output error_code,
        output active_persona, output goal_persona, output fallback_persona,
        output transition_count, input ready
    );
    modport sink (
        input valid, input accepted, input new_state, input error_code,
        input active_persona, input goal_persona, input fallback_persona,
        input transition_count, output ready
    );
endinterface

// ----- rtl/core/persona_reload_sequencer.sv -----
// ----------------------------------------------------------------------------
// persona_reload_sequencer
// event-driven sequencer for safe persona (function image) swaps
// ----------------------------------------------------------------------------
// One event transfer is taken per cycle and yields one status result offered in the
// next cycle. The next state is a single pass of combinational logic from the
// state registers and the event payload into the state and status registers;
// the event side stays ready while the status register is empty or is being
// drained, so a stalled status sink is the only thing that slows the block.
// A write to the boot persona register restarts the sequencer with that
// persona and clears the count, the error and the saved personas.
module persona_reload_sequencer
    import prs_pkg::*;
#(
    parameter int PERSONA_BITS = PERSONA_BITS_D
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [PERSONA_W-1:0] cfg_wdata,
    prs_event_if.sink            evt,
    prs_status_if.source         status
);

    typedef logic [PERSONA_BITS-1:0] img_t;

    state_t st_reg, st_next;
    img_t   cur_reg, cur_next;
    img_t   prev_reg, prev_next;
    img_t   tgt_reg, tgt_next;
    error_t err_reg, err_next;
    count_t cnt_reg, cnt_next;
    logic   ok;

    logic     out_valid_reg;
    logic     out_ok_reg;
    logic     in_fire;
    img_t     req_img;
    img_t     boot_img;
    logic [31:0] cur_wide, tgt_wide, prev_wide;

    assign in_fire   = evt.valid && evt.ready;
    assign evt.ready = !out_valid_reg || status.ready;
    assign req_img   = PERSONA_BITS'(32'(evt.wanted_persona));
    assign boot_img  = PERSONA_BITS'(32'(cfg_wdata));

    always_comb
    begin
        st_next   = st_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        tgt_next  = tgt_reg;
        err_next  = err_reg;
        cnt_next  = cnt_reg + 32'd1;
        ok        = 1'b1;
        unique case (st_reg) inside
            ST_STOPPED, ST_ACTIVE:
            begin
                if (evt.opcode == OP_RESET)
                begin
                    st_next   = ST_STOPPED;
                    cur_next  = '0;
                    prev_next = '0;
                    tgt_next  = '0;
                    err_next  = ER_NONE;
                    cnt_next  = '0;
                end
                else if (evt.opcode == OP_REQUEST)
                begin
                    prev_next = cur_reg;
                    tgt_next  = req_img;
                    st_next   = ST_VALIDATING;
                    err_next  = ER_NONE;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            ST_VALIDATING:
            begin
                if (evt.opcode == OP_INVALID || evt.opcode == OP_BUSY)
                begin
                    tgt_next = cur_reg;
                    st_next  = (cur_reg == '0) ? ST_STOPPED : ST_ACTIVE;
                    err_next = (evt.opcode == OP_INVALID) ? ER_INVALID : ER_BUSY;
                end
                else if (evt.opcode == OP_RETAIN && tgt_reg == cur_reg)
                begin
                    st_next  = ST_ACTIVE;
                    err_next = ER_NONE;
                end
                else if (evt.opcode == OP_VALID)
                begin
                    st_next  = ST_QUIESCING;
                    err_next = ER_NONE;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            ST_QUIESCING:
            begin
                if (evt.opcode == OP_QUIESCED)
                begin
                    st_next  = ST_UNLOADING;
                    err_next = ER_NONE;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            ST_UNLOADING:
            begin
                if (evt.opcode == OP_UNLOADED)
                begin
                    st_next  = ST_LOADING;
                    err_next = ER_NONE;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            ST_LOADING:
            begin
                if (evt.opcode == OP_LOADED)
                begin
                    cur_next = tgt_reg;
                    st_next  = ST_ACTIVE;
                    err_next = ER_NONE;
                end
                else if (evt.opcode == OP_LOAD_FAILED)
                begin
                    st_next  = ST_ROLLBACK;
                    err_next = ER_LOAD;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            ST_ROLLBACK:
            begin
                if (evt.opcode == OP_RB_LOADED)
                begin
                    cur_next = prev_reg;
                    tgt_next = prev_reg;
                    st_next  = (prev_reg == '0) ? ST_STOPPED : ST_ACTIVE;
                    err_next = ER_LOAD;
                end
                else if (evt.opcode == OP_RB_FAILED)
                begin
                    cur_next = '0;
                    tgt_next = '0;
                    st_next  = ST_FAULT;
                    err_next = ER_ROLLBACK;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            ST_FAULT:
            begin
                if (evt.opcode == OP_RESET)
                begin
                    st_next   = ST_STOPPED;
                    cur_next  = '0;
                    prev_next = '0;
                    tgt_next  = '0;
                    err_next  = ER_NONE;
                    cnt_next  = '0;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
        endcase
        // illegal event: personas untouched
        if (!ok)
        begin
            st_next   = ST_FAULT;
            err_next  = ER_TRANSITION;
            cur_next  = cur_reg;
            prev_next = prev_reg;
            tgt_next  = tgt_reg;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_STOPPED;
            cur_reg  <= '0;
            prev_reg <= '0;
            tgt_reg  <= '0;
            err_reg  <= ER_NONE;
            cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            st_reg   <= (boot_img == '0) ? ST_STOPPED : ST_ACTIVE;
            cur_reg  <= boot_img;
            prev_reg <= '0;
            tgt_reg  <= '0;
            err_reg  <= ER_NONE;
            cnt_reg  <= '0;
        end
        else if (in_fire)
        begin
            st_reg   <= st_next;
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            tgt_reg  <= tgt_next;
            err_reg  <= err_next;
            cnt_reg  <= cnt_next;
        end
    end

    // status register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_ok_reg <= ok;
        end
    end

    assign cur_wide  = 32'(cur_reg);
    assign tgt_wide  = 32'(tgt_reg);
    assign prev_wide = 32'(prev_reg);

    assign status.valid            = out_valid_reg;
    assign status.accepted         = out_ok_reg;
    assign status.new_state        = st_reg;
    assign status.error_code       = err_reg;
    assign status.active_persona   = cur_wide[PERSONA_W-1:0];
    assign status.goal_persona     = tgt_wide[PERSONA_W-1:0];
    assign status.fallback_persona = prev_wide[PERSONA_W-1:0];
    assign status.transition_count = cnt_reg;

`ifndef NO_ASSERTIONS
    a_reject_faults: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (st_reg == ST_FAULT))
        else $error("rejected event did not leave fault state");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_we && !(evt.opcode == OP_RESET &&
            (st_reg == ST_STOPPED || st_reg == ST_ACTIVE || st_reg == ST_FAULT)))
        |=> (cnt_reg == $past(cnt_reg) + 32'd1))
        else $error("transition count did not advance");

    a_fault_error: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_FAULT) |-> (err_reg == ER_ROLLBACK || err_reg == ER_TRANSITION))
        else $error("fault state without a fault error");

    a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_STOPPED) |-> (cur_reg == '0))
        else $error("stopped state with a nonzero persona");
`endif

endmodule
